### rtl/clr_pkg.sv
package clr_pkg;

    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int TWICE_W = 13;
    localparam int ERR_W   = 15;
    localparam int COLOR_W = 32;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic REG_SURFACE_WIDTH  = 1'b0;
    localparam logic REG_SURFACE_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic               command;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [31:0]        pixel_color;
    } t_cmd_item;

    typedef struct packed {
        logic        valid_res;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [31:0] out_color;
        logic        last_pixel;
    } t_pixel_item;

    // Line setup, worked out from a start command before it reaches the stepper
    typedef struct packed {
        logic                    command;
        logic [COORD_W-1:0]      x0;
        logic [COORD_W-1:0]      y0;
        logic [COORD_W-1:0]      x1;
        logic [COORD_W-1:0]      y1;
        logic [TWICE_W-1:0]      twice_dx;
        logic [TWICE_W-1:0]      twice_dy;
        logic                    neg_x;
        logic                    neg_y;
        logic                    x_major;
        logic signed [ERR_W-1:0] error_init;
        logic                    last_init;
        logic [COLOR_W-1:0]      color;
    } t_line_setup;

endpackage

### rtl/clr_setup.sv
module clr_setup
    import clr_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_width,
    input  logic [SIZE_W-1:0] i_height,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_cmd_item         i_in_item,
    output logic              o_s1_valid,
    input  logic              i_s1_ready,
    output t_line_setup       o_s1_setup
);

    localparam int LIM_CAP = (MAX_DIM < 4096) ? MAX_DIM : 4096;
    localparam logic [SIZE_W-1:0] CAP_VAL = SIZE_W'(LIM_CAP);
    localparam logic [SIZE_W-1:0] CAP_M1  = SIZE_W'(LIM_CAP - 1);

    logic                     r_valid;
    t_line_setup              r_setup;
    t_line_setup              n_setup;
    logic [SIZE_W-1:0]        lim_x;
    logic [SIZE_W-1:0]        lim_y;
    logic [COORD_W-1:0]       cx0;
    logic [COORD_W-1:0]       cy0;
    logic [COORD_W-1:0]       cx1;
    logic [COORD_W-1:0]       cy1;
    logic signed [COORD_W:0]  dx;
    logic signed [COORD_W:0]  dy;
    logic [COORD_W:0]         adx_w;
    logic [COORD_W:0]         ady_w;
    logic [COORD_W-1:0]       adx;
    logic [COORD_W-1:0]       ady;
    logic                     major;

    function automatic logic [SIZE_W-1:0] max_coord(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] lm;
        if (size == '0) begin
            lm = '0;
        end else if (size > CAP_VAL) begin
            lm = CAP_M1;
        end else begin
            lm = size - SIZE_W'(1);
        end
        return lm;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [15:0] v,
                                                       input logic [SIZE_W-1:0] lm);
        logic [COORD_W-1:0] c;
        if (v[15]) begin
            c = '0;
        end else if (v[14:0] > {2'b00, lm}) begin
            c = lm[COORD_W-1:0];
        end else begin
            c = v[COORD_W-1:0];
        end
        return c;
    endfunction

    always_comb begin
        lim_x = max_coord(i_width);
        lim_y = max_coord(i_height);
        cx0   = clamp_coord(i_in_item.start_x, lim_x);
        cy0   = clamp_coord(i_in_item.start_y, lim_y);
        cx1   = clamp_coord(i_in_item.end_x, lim_x);
        cy1   = clamp_coord(i_in_item.end_y, lim_y);
        dx    = $signed({1'b0, cx1}) - $signed({1'b0, cx0});
        dy    = $signed({1'b0, cy1}) - $signed({1'b0, cy0});
        adx_w = dx[COORD_W] ? -dx : dx;
        ady_w = dy[COORD_W] ? -dy : dy;
        adx   = adx_w[COORD_W-1:0];
        ady   = ady_w[COORD_W-1:0];
        major = adx > ady;

        n_setup.command    = i_in_item.command;
        n_setup.x0         = cx0;
        n_setup.y0         = cy0;
        n_setup.x1         = cx1;
        n_setup.y1         = cy1;
        n_setup.twice_dx   = {adx, 1'b0};
        n_setup.twice_dy   = {ady, 1'b0};
        n_setup.neg_x      = dx[COORD_W];
        n_setup.neg_y      = dy[COORD_W];
        n_setup.x_major    = major;
        n_setup.error_init = major
            ? $signed({2'b00, ady, 1'b0}) - $signed({3'b000, adx})
            : $signed({2'b00, adx, 1'b0}) - $signed({3'b000, ady});
        n_setup.last_init  = major ? (cx0 == cx1) : (cy0 == cy1);
        n_setup.color      = i_in_item.pixel_color;
    end

    assign o_in_ready = !r_valid || i_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_setup <= n_setup;
        end
    end

    assign o_s1_valid = r_valid;
    assign o_s1_setup = r_setup;

endmodule

### rtl/clr_stepper.sv
module clr_stepper
    import clr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s1_valid,
    output logic        o_s1_ready,
    input  t_line_setup i_s1_setup,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pixel_item o_out_item
);

    logic                    r_busy;
    logic [COORD_W-1:0]      r_cur_x;
    logic [COORD_W-1:0]      r_cur_y;
    logic [COORD_W-1:0]      r_goal_x;
    logic [COORD_W-1:0]      r_goal_y;
    logic [TWICE_W-1:0]      r_twice_dx;
    logic [TWICE_W-1:0]      r_twice_dy;
    logic                    r_neg_x;
    logic                    r_neg_y;
    logic                    r_x_major;
    logic signed [ERR_W-1:0] r_error;
    logic [COLOR_W-1:0]      r_color;
    logic                    r_out_valid;
    t_pixel_item             r_out;

    logic                    n_busy;
    logic [COORD_W-1:0]      n_cur_x;
    logic [COORD_W-1:0]      n_cur_y;
    logic signed [ERR_W-1:0] n_error;
    t_pixel_item             n_out;

    logic                    take;
    logic                    is_start;
    logic                    last;
    logic [COORD_W-1:0]      step_x;
    logic [COORD_W-1:0]      step_y;
    logic signed [ERR_W-1:0] err_minor;
    logic signed [ERR_W-1:0] tdx_s;
    logic signed [ERR_W-1:0] tdy_s;

    assign o_s1_ready = !r_out_valid || i_out_ready;
    assign take       = i_s1_valid && o_s1_ready;
    assign is_start   = (i_s1_setup.command == CMD_START);

    always_comb begin
        step_x  = r_neg_x ? r_cur_x - COORD_W'(1) : r_cur_x + COORD_W'(1);
        step_y  = r_neg_y ? r_cur_y - COORD_W'(1) : r_cur_y + COORD_W'(1);
        tdx_s   = $signed({2'b00, r_twice_dx});
        tdy_s   = $signed({2'b00, r_twice_dy});
        n_busy  = r_busy;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_error = r_error;
        last    = 1'b0;
        err_minor = r_error;

        if (is_start) begin
            n_cur_x = i_s1_setup.x0;
            n_cur_y = i_s1_setup.y0;
            n_error = i_s1_setup.error_init;
            last    = i_s1_setup.last_init;
            n_busy  = !i_s1_setup.last_init;
        end else if (r_busy) begin
            if (r_x_major) begin
                // minor step in y when the error has gone non-negative
                if (!r_error[ERR_W-1]) begin
                    n_cur_y   = step_y;
                    err_minor = r_error - tdx_s;
                end
                n_cur_x = step_x;
                n_error = err_minor + tdy_s;
                last    = (step_x == r_goal_x);
            end else begin
                if (!r_error[ERR_W-1]) begin
                    n_cur_x   = step_x;
                    err_minor = r_error - tdy_s;
                end
                n_cur_y = step_y;
                n_error = err_minor + tdx_s;
                last    = (step_y == r_goal_y);
            end
            n_busy = !last;
        end

        n_out.valid_res  = is_start || r_busy;
        n_out.out_x      = n_out.valid_res ? n_cur_x : '0;
        n_out.out_y      = n_out.valid_res ? n_cur_y : '0;
        n_out.out_color  = is_start ? i_s1_setup.color : (r_busy ? r_color : '0);
        n_out.last_pixel = n_out.valid_res && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= n_busy;
            end
            if (o_s1_ready) begin
                r_out_valid <= i_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_error <= n_error;
            r_out   <= n_out;
            // latch the line geometry on start only
            if (is_start) begin
                r_goal_x   <= i_s1_setup.x1;
                r_goal_y   <= i_s1_setup.y1;
                r_twice_dx <= i_s1_setup.twice_dx;
                r_twice_dy <= i_s1_setup.twice_dy;
                r_neg_x    <= i_s1_setup.neg_x;
                r_neg_y    <= i_s1_setup.neg_y;
                r_x_major  <= i_s1_setup.x_major;
                r_color    <= i_s1_setup.color;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/clamped_line_rasterizer_top.sv
// Bresenham line engine with endpoint clamping. Every command transfer gives
// exactly one result transfer: a start command (command = 0) clamps both
// endpoints into the surface set by surface_width / surface_height (byte
// addresses 0 and 4) and returns the first pixel; each advance command
// (command = 1) returns the next pixel, with last_pixel set on the end point.
// An advance with no line in progress returns a result with valid_res = 0.
// One command is taken per clock while the result output is not stalled; its
// result passes one register stage for clamping and delta setup, then one
// for the stepping state, which is updated in place on each pixel. Write the
// surface size registers only while no command is in flight.
module clamped_line_rasterizer_top
    import clr_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_cmd_item   i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pixel_item o_out_item
);

    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic              cfg_write;
    logic              s1_valid;
    logic              s1_ready;
    t_line_setup       s1_setup;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_SURFACE_WIDTH:  r_width  <= pwdata[SIZE_W-1:0];
                REG_SURFACE_HEIGHT: r_height <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SURFACE_WIDTH:  prdata = {19'd0, r_width};
            REG_SURFACE_HEIGHT: prdata = {19'd0, r_height};
            default:            prdata = '0;
        endcase
    end

    clr_setup #(
        .MAX_DIM (MAX_DIM)
    ) u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_s1_valid (s1_valid),
        .i_s1_ready (s1_ready),
        .o_s1_setup (s1_setup)
    );

    clr_stepper u_stepper (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .o_s1_ready  (s1_ready),
        .i_s1_setup  (s1_setup),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
